[sv/rpn_pkg.sv]
// Package: types and codes for the RPN stack evaluator.
`timescale 1ns / 1ps
package rpn_pkg;
  localparam logic [1:0] OPC_PUSH = 2'd0;
  localparam logic [1:0] OPC_ALU = 2'd1;
  localparam logic [1:0] OPC_STD = 2'd2;
  localparam logic [1:0] OPC_STP = 2'd3;

  localparam logic [3:0] ALU_OR = 4'd0;
  localparam logic [3:0] ALU_XOR = 4'd1;
  localparam logic [3:0] ALU_AND = 4'd2;
  localparam logic [3:0] ALU_SHL = 4'd3;
  localparam logic [3:0] ALU_SHR = 4'd4;
  localparam logic [3:0] ALU_ADD = 4'd5;
  localparam logic [3:0] ALU_SUB = 4'd6;
  localparam logic [3:0] ALU_MUL = 4'd7;
  localparam logic [3:0] ALU_DIV = 4'd8;
  localparam logic [3:0] ALU_MOD = 4'd9;
  localparam logic [3:0] ALU_NEG = 4'd10;
  localparam logic [3:0] ALU_NOT = 4'd11;
  localparam logic [3:0] ALU_POW = 4'd12;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER = 2'd2;
  localparam logic [1:0] ERR_DIVZ = 2'd3;

  localparam logic [15:0] LOW_MASK = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  alu_op;
    logic        swap_operands;
    logic signed [31:0] push_value;
    logic [15:0] store_address;
    logic [15:0] existing_literal;
  } in_item_t;

  typedef struct packed {
    logic        target_memory;
    logic [15:0] write_address;
    logic [15:0] write_data;
    logic [1:0]  error_code;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_RD1, ST_RD2, ST_EXEC, ST_DIV, ST_POW, ST_WB, ST_EMIT
  } state_t;
endpackage

[sv/rpn_stack_evaluator.sv]
// Top level: RPN stack evaluator with an iterative shared arithmetic unit.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_stall/in_data carries one RPN action per transfer.
//   Output channel out_valid/out_stall/out_data carries store writes and error
//   reports (zero or one per action). in_stall is high while an action is in
//   work or a result waits to be taken; one action at a time.
//   States per action: push decodes and emits; store adds RD1 and EXEC;
//   neg/not add RD1, EXEC and WB; other binary ops also add RD2.
//   div/mod add a radix-2 restoring divider, one quotient bit a cycle.
//   pow adds square-and-multiply on one 32x32 multiplier, two multiplies
//   per exponent bit, ending when the exponent runs out. The stack is a
//   memory with one registered read port, so binary ops take two read
//   states, RD1 and RD2.
//   Reset (rst_n low, synchronous) empties the stack; stack contents are not
//   cleared. While the receiver stalls a result stays on out_data and no new
//   action is taken.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rpn_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rpn_pkg::out_item_t out_data
);
  import rpn_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] DEPTH_C = PW'(STACK_DEPTH);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_q;

  state_t st_r, st_nxt;
  in_item_t it_r;
  logic [PW-1:0] sp_r, sp_nxt;
  logic [31:0] a_r, a_nxt;               // top of stack for binary ops
  logic [31:0] l_r, l_nxt, r_r, r_nxt;
  logic [31:0] acc_r, acc_nxt;           // result / quotient / power result
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        ph_r, ph_nxt;
  logic        nl_r, nl_nxt, nr_r, nr_nxt;
  out_item_t   o_r, o_nxt;
  logic        ov_r, ov_nxt;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  // stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // shared multiplier
  logic [31:0] mx, my, mp;
  assign mp = mx * my;

  // divider step
  logic [32:0] trial;
  logic [31:0] rsh;
  always_comb begin
    rsh   = {rem_r[30:0], acc_r[31]};
    trial = {1'b0, rsh} - {1'b0, r_r};
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (in_valid) st_nxt = ST_DECODE;
      ST_DECODE: begin
        st_nxt = ST_RD1;
        case (it_r.opcode)
          OPC_PUSH: st_nxt = ST_EMIT;
          OPC_ALU: begin
            if (it_r.alu_op > ALU_POW) st_nxt = ST_EMIT;
            else if (it_r.alu_op == ALU_NEG || it_r.alu_op == ALU_NOT) begin
              if (sp_r < PW'(1)) st_nxt = ST_EMIT;
            end else if (sp_r < PW'(2)) st_nxt = ST_EMIT;
          end
          default: if (sp_r < PW'(1)) st_nxt = ST_EMIT;
        endcase
      end
      ST_RD1: begin
        if (it_r.opcode != OPC_ALU || it_r.alu_op == ALU_NEG || it_r.alu_op == ALU_NOT)
          st_nxt = ST_EXEC;
        else st_nxt = ST_RD2;
      end
      ST_RD2: st_nxt = ST_EXEC;
      ST_EXEC: begin
        if (it_r.opcode != OPC_ALU) st_nxt = ST_EMIT;
        else if ((it_r.alu_op == ALU_DIV || it_r.alu_op == ALU_MOD) && r_nxt != 32'd0)
          st_nxt = ST_DIV;
        else if (it_r.alu_op == ALU_POW && !r_nxt[31] && r_nxt != 32'd0) st_nxt = ST_POW;
        else st_nxt = ST_WB;
      end
      ST_DIV: if (cnt_r == 6'd31) st_nxt = ST_WB;
      ST_POW: if (ph_r && r_r[31:1] == 31'd0) st_nxt = ST_WB;
      ST_WB:  st_nxt = ST_EMIT;
      ST_EMIT: if (!ov_r || !out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sp_nxt = sp_r; a_nxt = a_r; l_nxt = l_r; r_nxt = r_r;
    acc_nxt = acc_r; rem_nxt = rem_r; cnt_nxt = cnt_r; ph_nxt = ph_r;
    nl_nxt = nl_r; nr_nxt = nr_r; o_nxt = o_r; ov_nxt = ov_r;
    we = 1'b0; waddr = '0; wdata = it_r.push_value;
    raddr = AW'(sp_r - PW'(1));
    mx = acc_r; my = l_r;
    case (st_r)
      ST_IDLE: ov_nxt = 1'b0;
      ST_DECODE: begin
        o_nxt = '0;
        case (it_r.opcode)
          OPC_PUSH: begin
            if (sp_r >= DEPTH_C) begin
              o_nxt.error_code = ERR_OVER; ov_nxt = 1'b1;
            end else begin
              we = 1'b1; waddr = AW'(sp_r); sp_nxt = sp_r + PW'(1);
            end
          end
          OPC_ALU: begin
            if (it_r.alu_op <= ALU_POW) begin
              if (it_r.alu_op == ALU_NEG || it_r.alu_op == ALU_NOT) begin
                if (sp_r < PW'(1)) begin
                  o_nxt.error_code = ERR_UNDER; ov_nxt = 1'b1;
                end
              end else if (sp_r < PW'(2)) begin
                o_nxt.error_code = ERR_UNDER; ov_nxt = 1'b1;
              end
            end
          end
          default: if (sp_r < PW'(1)) begin
            o_nxt.error_code = ERR_UNDER; ov_nxt = 1'b1;
          end
        endcase
      end
      // binary ops fetch the next word; others keep reading the top
      ST_RD1: begin
        if (it_r.opcode == OPC_ALU && it_r.alu_op != ALU_NEG && it_r.alu_op != ALU_NOT)
          raddr = AW'(sp_r - PW'(2));
      end
      ST_RD2: raddr = AW'(sp_r - PW'(2));
      ST_EXEC: begin
        if (it_r.opcode != OPC_ALU) begin
          sp_nxt = sp_r - PW'(1);
          o_nxt.target_memory = (it_r.opcode == OPC_STP);
          o_nxt.write_address = it_r.store_address;
          o_nxt.write_data = (it_r.opcode == OPC_STP) ?
            (rd_q[15:0] + it_r.existing_literal) & LOW_MASK : rd_q[15:0];
          ov_nxt = 1'b1;
        end else if (it_r.alu_op == ALU_NEG || it_r.alu_op == ALU_NOT) begin
          acc_nxt = (it_r.alu_op == ALU_NEG) ? 32'd0 - rd_q : ~rd_q;
        end else begin
          // a_r holds top, rd_q holds next
          l_nxt = it_r.swap_operands ? a_r : rd_q;
          r_nxt = it_r.swap_operands ? rd_q : a_r;
          case (it_r.alu_op)
            ALU_OR:  acc_nxt = l_nxt | r_nxt;
            ALU_XOR: acc_nxt = l_nxt ^ r_nxt;
            ALU_AND: acc_nxt = l_nxt & r_nxt;
            ALU_SHL: acc_nxt = (r_nxt > 32'd31) ? 32'd0 : l_nxt << r_nxt[4:0];
            ALU_SHR: acc_nxt = (r_nxt > 32'd31) ? {32{l_nxt[31]}} :
                               32'($signed(l_nxt) >>> r_nxt[4:0]);
            ALU_ADD: acc_nxt = l_nxt + r_nxt;
            ALU_SUB: acc_nxt = l_nxt - r_nxt;
            ALU_MUL: acc_nxt = 32'd0; // done in WB via shared multiplier
            ALU_DIV, ALU_MOD: begin
              nl_nxt = l_nxt[31]; nr_nxt = r_nxt[31];
              acc_nxt = l_nxt[31] ? 32'd0 - l_nxt : l_nxt;
              rem_nxt = 32'd0; cnt_nxt = 6'd0;
              if (r_nxt == 32'd0) begin
                acc_nxt = 32'd0; o_nxt.error_code = ERR_DIVZ; ov_nxt = 1'b1;
              end else if (r_nxt[31]) r_nxt = 32'd0 - r_nxt;
            end
            default: begin // pow
              acc_nxt = 32'd1; ph_nxt = 1'b0;
              if (r_nxt[31]) begin
                if (l_nxt == 32'd1) acc_nxt = 32'd1;
                else if (l_nxt == 32'hFFFFFFFF) acc_nxt = r_nxt[0] ? l_nxt : 32'd1;
                else acc_nxt = 32'd0;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (!trial[32]) begin
          rem_nxt = trial[31:0]; acc_nxt = {acc_r[30:0], 1'b1};
        end else begin
          rem_nxt = rsh; acc_nxt = {acc_r[30:0], 1'b0};
        end
      end
      ST_POW: begin
        // phase 0: multiply result by base if bit set; phase 1: square base
        ph_nxt = !ph_r;
        if (!ph_r) begin
          mx = acc_r; my = l_r;
          if (r_r[0]) acc_nxt = mp;
        end else begin
          mx = l_r; my = l_r;
          l_nxt = mp; r_nxt = {1'b0, r_r[31:1]};
        end
      end
      ST_WB: begin
        we = 1'b1;
        if (it_r.alu_op == ALU_NEG || it_r.alu_op == ALU_NOT) begin
          waddr = AW'(sp_r - PW'(1)); wdata = acc_r;
        end else begin
          sp_nxt = sp_r - PW'(1);
          waddr = AW'(sp_r - PW'(2));
          mx = l_r; my = r_r;
          case (it_r.alu_op)
            ALU_MUL: wdata = mp;
            ALU_DIV: wdata = (o_r.error_code != ERR_NONE) ? 32'd0 :
                             ((nl_r != nr_r) ? 32'd0 - acc_r : acc_r);
            ALU_MOD: wdata = (o_r.error_code != ERR_NONE) ? 32'd0 :
                             (nl_r ? 32'd0 - rem_r : rem_r);
            default: wdata = acc_r;
          endcase
        end
      end
      ST_EMIT: if (!out_stall) ov_nxt = 1'b0;
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; sp_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sp_r <= sp_nxt; ov_r <= ov_nxt;
    end
    if (st_r == ST_IDLE && in_valid) it_r <= in_data;
    if (st_r == ST_RD1) a_r <= rd_q;
    else a_r <= a_nxt;
    l_r <= l_nxt; r_r <= r_nxt; acc_r <= acc_nxt; rem_r <= rem_nxt;
    cnt_r <= cnt_nxt; ph_r <= ph_nxt; nl_r <= nl_nxt; nr_r <= nr_nxt; o_r <= o_nxt;
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = ov_r && (st_r == ST_EMIT);
  assign out_data  = o_r;

  // checks
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n) sp_r <= DEPTH_C)
    else $error("stack pointer beyond depth");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while accepting");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != ERR_NONE) |->
      (out_data.write_address == 16'd0 && !out_data.target_memory))
    else $error("error result with nonzero payload");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> cnt_r <= 6'd31) else $error("divider overrun");
endmodule
